// ----- src/srfp_pkg.sv -----
// Shared types and constants of the speech response frame parser.
`default_nettype none
package srfp_pkg;

	// Message type nibble values.
	localparam logic [3:0] MSG_FULL  = 4'h9;
	localparam logic [3:0] MSG_AUDIO = 4'hB;
	localparam logic [3:0] MSG_ERROR = 4'hF;

	// Flags nibble value that announces an event field.
	localparam logic [3:0] FLAGS_EVENT = 4'h4;

	// Compression nibble value for gzip payloads.
	localparam logic [3:0] COMP_GZIP = 4'h1;

	// Event numbers with a special meaning.
	localparam logic [31:0] EV_CONN_OPEN  = 32'd50;
	localparam logic [31:0] EV_CONN_FAIL  = 32'd51;
	localparam logic [31:0] EV_CONN_CLOSE = 32'd52;
	localparam logic [31:0] EV_SESS_DONE  = 32'd152;
	localparam logic [31:0] EV_SESS_FAIL  = 32'd153;

	// Frame status codes reported on the frame-end beat.
	typedef enum logic [3:0] {
		ST_OK           = 4'd0,
		ST_SHORT        = 4'd1,
		ST_HDR_SIZE     = 4'd2,
		ST_SEQ          = 4'd3,
		ST_ERR_CODE     = 4'd4,
		ST_EVENT        = 4'd5,
		ST_SESSION_ID   = 4'd6,
		ST_CONNECT_ID   = 4'd7,
		ST_PAYLOAD_SIZE = 4'd8,
		ST_SERVER_ERR   = 4'd9
	} stat_t;

	// One result beat.
	typedef struct packed {
		logic               payload_valid;
		logic [7:0]         payload_byte;
		logic               status_valid;
		stat_t              status;
		logic [3:0]         message_kind;
		logic [3:0]         flag_bits;
		logic               is_compressed;
		logic signed [31:0] event_code;
		logic signed [31:0] sequence_value;
		logic [31:0]        server_error_code;
		logic               final_seen;
		logic [31:0]        audio_total;
	} res_t;

	// Frame completion request from the parser to the running totals.
	typedef struct packed {
		logic        add_audio;
		logic [31:0] audio_amount;
		logic        set_final;
	} frame_done_t;

endpackage
`default_nettype wire

// ----- src/srfp_in_if.sv -----
// Input channel of the frame parser: one raw frame byte per beat.
`default_nettype none
interface srfp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] frame_byte;
	logic       frame_end;
	logic       clear_totals;

	modport source(output valid, frame_byte, frame_end, clear_totals, input ready);
	modport sink(input valid, frame_byte, frame_end, clear_totals, output ready);
endinterface
`default_nettype wire

// ----- src/srfp_out_if.sv -----
// Result channel of the frame parser: payload bytes and frame status.
`default_nettype none
interface srfp_out_if;
	logic               valid;
	logic               ready;
	logic               payload_valid;
	logic [7:0]         payload_byte;
	logic               status_valid;
	logic [3:0]         status;
	logic [3:0]         message_kind;
	logic [3:0]         flag_bits;
	logic               is_compressed;
	logic signed [31:0] event_code;
	logic signed [31:0] sequence_value;
	logic [31:0]        server_error_code;
	logic               final_seen;
	logic [31:0]        audio_total;

	modport source(output valid, payload_valid, payload_byte, status_valid, status,
		message_kind, flag_bits, is_compressed, event_code, sequence_value,
		server_error_code, final_seen, audio_total, input ready);
	modport sink(input valid, payload_valid, payload_byte, status_valid, status,
		message_kind, flag_bits, is_compressed, event_code, sequence_value,
		server_error_code, final_seen, audio_total, output ready);
endinterface
`default_nettype wire

// ----- src/srfp_parse.sv -----
// Per-frame field parser: header, optional words, ID and payload tracking.
`default_nettype none
module srfp_parse
	import srfp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        step,
	input  wire logic [7:0]  frame_byte,
	input  wire logic        frame_end,
	output logic             has_result,
	output res_t             res,
	output frame_done_t      done
);

	typedef enum logic [3:0] {
		PH_HDR, PH_SEQ, PH_ERRC, PH_EVT, PH_IDLEN, PH_IDBODY, PH_PLEN, PH_DATA,
		PH_TAIL, PH_FAIL
	} phase_t;

	phase_t      phase_q, phase_n;
	logic [31:0] fc_q, fc_n;
	logic [5:0]  idx_q, idx_n;
	logic [31:0] shift_q, shift_n;
	logic [3:0]  hsize_q, hsize_n;
	logic [3:0]  type_q, type_n;
	logic [3:0]  flags_q, flags_n;
	logic        gzip_q, gzip_n;
	logic [31:0] event_q, event_n;
	logic [31:0] seq_q, seq_n;
	logic [31:0] errc_q, errc_n;
	logic [31:0] faud_q, faud_n;

	logic        word_last;
	logic [5:0]  word_idx;
	logic [5:0]  hdr_idx;
	logic [5:0]  hdr_len;
	logic [31:0] fc_dec;
	logic        has_seq;
	logic        conn_event;
	phase_t      after_errc;
	phase_t      after_seq;
	phase_t      after_hdr;
	stat_t       st;
	logic        pv;

	always_comb begin
		phase_n = phase_q;
		fc_n    = fc_q;
		idx_n   = idx_q;
		hsize_n = hsize_q;
		type_n  = type_q;
		flags_n = flags_q;
		gzip_n  = gzip_q;
		event_n = event_q;
		seq_n   = seq_q;
		errc_n  = errc_q;
		faud_n  = faud_q;
		shift_n = {shift_q[23:0], frame_byte};

		word_last = (idx_q[1:0] == 2'd3);
		word_idx  = word_last ? 6'd0 : idx_q + 6'd1;
		hdr_idx   = idx_q + 6'd1;
		hdr_len   = {hsize_q, 2'b00};
		fc_dec    = fc_q - 32'd1;

		has_seq    = (flags_q >= 4'd1) && (flags_q <= 4'd3);
		after_errc = (flags_q == FLAGS_EVENT) ? PH_EVT : PH_PLEN;
		after_seq  = (type_q == MSG_ERROR) ? PH_ERRC : after_errc;
		after_hdr  = has_seq ? PH_SEQ : after_seq;

		pv   = 1'b0;
		st   = ST_OK;
		done = '0;

		case (phase_q)
			PH_HDR: begin
				if (idx_q == 6'd0) begin
					hsize_n = frame_byte[3:0];
				end else if (idx_q == 6'd1) begin
					type_n  = frame_byte[7:4];
					flags_n = frame_byte[3:0];
				end else if (idx_q == 6'd2) begin
					gzip_n = (frame_byte[3:0] == COMP_GZIP);
				end
				idx_n = hdr_idx;
				if (hdr_idx >= 6'd4) begin
					if (hdr_len == 6'd0) begin
						phase_n = PH_FAIL;
					end else if (hdr_idx >= hdr_len) begin
						idx_n   = 6'd0;
						phase_n = after_hdr;
					end
				end
			end
			PH_SEQ: begin
				idx_n = word_idx;
				if (word_last) begin
					seq_n   = shift_n;
					phase_n = after_seq;
				end
			end
			PH_ERRC: begin
				idx_n = word_idx;
				if (word_last) begin
					errc_n  = shift_n;
					phase_n = after_errc;
				end
			end
			PH_EVT: begin
				idx_n = word_idx;
				if (word_last) begin
					event_n = shift_n;
					phase_n = PH_IDLEN;
				end
			end
			PH_IDLEN: begin
				idx_n = word_idx;
				if (word_last) begin
					fc_n    = shift_n;
					phase_n = (shift_n == 32'd0) ? PH_PLEN : PH_IDBODY;
				end
			end
			PH_IDBODY: begin
				fc_n = fc_dec;
				if (fc_dec == 32'd0) begin
					phase_n = PH_PLEN;
				end
			end
			PH_PLEN: begin
				idx_n = word_idx;
				if (word_last) begin
					fc_n    = shift_n;
					phase_n = (shift_n == 32'd0) ? PH_TAIL : PH_DATA;
				end
			end
			PH_DATA: begin
				pv     = 1'b1;
				faud_n = faud_q + 32'd1;
				fc_n   = fc_dec;
				if (fc_dec == 32'd0) begin
					phase_n = PH_TAIL;
				end
			end
			default: begin
			end
		endcase

		conn_event = (event_n == EV_CONN_OPEN) || (event_n == EV_CONN_FAIL) ||
			(event_n == EV_CONN_CLOSE);

		if (frame_end) begin
			case (phase_n)
				PH_HDR:    st = (idx_n < 6'd4) ? ST_SHORT : ST_HDR_SIZE;
				PH_SEQ:    st = ST_SEQ;
				PH_ERRC:   st = ST_ERR_CODE;
				PH_EVT:    st = ST_EVENT;
				PH_IDLEN,
				PH_IDBODY: st = conn_event ? ST_CONNECT_ID : ST_SESSION_ID;
				PH_PLEN,
				PH_DATA:   st = ST_PAYLOAD_SIZE;
				PH_TAIL: begin
					if (type_n == MSG_AUDIO) begin
						done.add_audio    = 1'b1;
						done.audio_amount = faud_n;
						done.set_final    = (flags_n == 4'd2) || (flags_n == 4'd3) ||
							(has_seq && seq_n[31]);
					end else if ((type_n == MSG_ERROR) || (event_n == EV_CONN_FAIL) ||
						(event_n == EV_SESS_FAIL)) begin
						done.set_final = 1'b1;
						st             = ST_SERVER_ERR;
					end else if ((type_n == MSG_FULL) && (event_n == EV_SESS_DONE)) begin
						done.set_final = 1'b1;
					end
				end
				default:   st = ST_HDR_SIZE;
			endcase
		end

		res               = '0;
		res.payload_valid = pv;
		res.payload_byte  = pv ? frame_byte : 8'd0;
		if (frame_end) begin
			res.status_valid      = 1'b1;
			res.status            = st;
			res.message_kind      = type_n;
			res.flag_bits         = flags_n;
			res.is_compressed     = gzip_n;
			res.event_code        = event_n;
			res.sequence_value    = seq_n;
			res.server_error_code = errc_n;

			// Every frame starts again from a clean header state.
			phase_n = PH_HDR;
			fc_n    = '0;
			idx_n   = '0;
			hsize_n = '0;
			type_n  = '0;
			flags_n = '0;
			gzip_n  = 1'b0;
			event_n = '0;
			seq_n   = '0;
			errc_n  = '0;
			faud_n  = '0;
		end
		has_result = pv || frame_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HDR;
			fc_q    <= '0;
			idx_q   <= '0;
			shift_q <= '0;
			hsize_q <= '0;
			type_q  <= '0;
			flags_q <= '0;
			gzip_q  <= 1'b0;
			event_q <= '0;
			seq_q   <= '0;
			errc_q  <= '0;
			faud_q  <= '0;
		end else if (step) begin
			phase_q <= phase_n;
			fc_q    <= fc_n;
			idx_q   <= idx_n;
			shift_q <= shift_n;
			hsize_q <= hsize_n;
			type_q  <= type_n;
			flags_q <= flags_n;
			gzip_q  <= gzip_n;
			event_q <= event_n;
			seq_q   <= seq_n;
			errc_q  <= errc_n;
			faud_q  <= faud_n;
		end
	end

endmodule
`default_nettype wire

// ----- src/srfp_totals.sv -----
// Running audio byte total and final-response mark across frames.
`default_nettype none
module srfp_totals
	import srfp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        step,
	input  wire logic        clear,
	input  wire frame_done_t done,
	output logic [31:0]      total_next,
	output logic             final_next
);

	logic [31:0] total_q;
	logic        final_q;
	logic [31:0] base_total;
	logic [32:0] sum;

	always_comb begin
		base_total = clear ? 32'd0 : total_q;
		sum        = {1'b0, base_total} + {1'b0, done.audio_amount};
		if (done.add_audio) begin
			total_next = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
		end else begin
			total_next = base_total;
		end
		final_next = (final_q && !clear) || done.set_final;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			final_q <= 1'b0;
		end else if (step) begin
			total_q <= total_next;
			final_q <= final_next;
		end
	end

endmodule
`default_nettype wire

// ----- src/speech_response_frame_parser_unit.sv -----
// Top level of the speech response frame parser.
//
// The frame channel carries one raw byte of a response frame per beat, with
// frame_end marking the last byte and clear_totals starting a new request.
// The result channel carries at most one beat per input beat: a payload byte
// while the frame body streams through, and a status beat on the frame-end
// byte. Header, sequence, error code, event and ID bytes produce no beat.
// An accepted byte is held in the input register, then the parser's single
// pass writes the result register. Unless the receiver stalls, the block
// takes a new byte every cycle; the parser state advances once per byte.
// Payload bytes leave before the frame is validated, so a consumer drops
// them when the closing status is not ok.
// While the receiver stalls, the result register holds its beat and the
// input register keeps accepting bytes that produce no result; a byte that
// would produce one waits in the input register and blocks the next byte.
// Reset clears all frame state, the audio total and the final mark; the
// block is ready for the first byte right after reset is released.
`default_nettype none
module speech_response_frame_parser_unit
	import srfp_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	srfp_in_if.sink     frame,
	srfp_out_if.source  result
);

	// Input register stage.
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        end_s1;
	logic        clear_s1;

	// Result register stage.
	logic        valid_s2;
	res_t        res_s2;

	logic        has_result;
	res_t        res_comb;
	res_t        res_load;
	frame_done_t done;
	logic [31:0] total_next;
	logic        final_next;
	logic        out_free;
	logic        fire;
	logic        accept;

	// The result register may be loaded when it is empty or being drained.
	assign out_free    = !valid_s2 || result.ready;
	// A byte without a result never waits on the receiver.
	assign fire        = valid_s1 && (out_free || !has_result);
	assign frame.ready = !valid_s1 || fire;
	assign accept      = frame.valid && frame.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1  <= frame.frame_byte;
			end_s1   <= frame.frame_end;
			clear_s1 <= frame.clear_totals;
		end
	end

	srfp_parse u_parse (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (fire),
		.frame_byte (byte_s1),
		.frame_end  (end_s1),
		.has_result (has_result),
		.res        (res_comb),
		.done       (done)
	);

	srfp_totals u_totals (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (fire),
		.clear      (clear_s1),
		.done       (done),
		.total_next (total_next),
		.final_next (final_next)
	);

	// The running totals only appear on status beats.
	always_comb begin
		res_load             = res_comb;
		res_load.final_seen  = end_s1 ? final_next : 1'b0;
		res_load.audio_total = end_s1 ? total_next : 32'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= fire && has_result;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && fire && has_result) begin
			res_s2 <= res_load;
		end
	end

	assign result.valid             = valid_s2;
	assign result.payload_valid     = res_s2.payload_valid;
	assign result.payload_byte      = res_s2.payload_byte;
	assign result.status_valid      = res_s2.status_valid;
	assign result.status            = res_s2.status;
	assign result.message_kind      = res_s2.message_kind;
	assign result.flag_bits         = res_s2.flag_bits;
	assign result.is_compressed     = res_s2.is_compressed;
	assign result.event_code        = res_s2.event_code;
	assign result.sequence_value    = res_s2.sequence_value;
	assign result.server_error_code = res_s2.server_error_code;
	assign result.final_seen        = res_s2.final_seen;
	assign result.audio_total       = res_s2.audio_total;

endmodule
`default_nettype wire

// ----- src/srfp_checker.sv -----
// Port-level assertions for the frame parser and their binding.
`default_nettype none
module srfp_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic        payload_valid,
	input wire logic [7:0]  payload_byte,
	input wire logic        status_valid,
	input wire logic [3:0]  status,
	input wire logic [31:0] event_code,
	input wire logic [31:0] sequence_value,
	input wire logic [31:0] server_error_code,
	input wire logic [31:0] audio_total
);

	// A stalled result beat keeps its contents.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(payload_byte) &&
		$stable(status) && $stable(audio_total))
		else $error("result beat changed while stalled");

	// Every result beat carries a payload byte or a status.
	a_no_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> payload_valid || status_valid)
		else $error("empty result beat");

	// Status fields read zero on beats without a status.
	a_status_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !status_valid |-> status == 4'd0 && event_code == 32'd0 &&
		sequence_value == 32'd0 && server_error_code == 32'd0 && audio_total == 32'd0)
		else $error("status fields set without status");

	// Payload byte reads zero when no payload byte is carried.
	a_payload_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !payload_valid |-> payload_byte == 8'd0)
		else $error("payload byte set without payload");

	// With the result register empty, the input side is never held off.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty result register");

endmodule

bind speech_response_frame_parser_unit srfp_checker u_srfp_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.in_ready          (frame.ready),
	.out_valid         (result.valid),
	.out_ready         (result.ready),
	.payload_valid     (result.payload_valid),
	.payload_byte      (result.payload_byte),
	.status_valid      (result.status_valid),
	.status            (result.status),
	.event_code        (result.event_code),
	.sequence_value    (result.sequence_value),
	.server_error_code (result.server_error_code),
	.audio_total       (result.audio_total)
);
`default_nettype wire
